### design/ecc_pkg.sv
package ecc_pkg;

   localparam int ECC_MAX_ITERATIONS = 5;
   localparam int ECC_FRACTION_BITS  = 16;
   localparam int ECC_ROUND_CAP      = 8;

   // Polygon coefficients, Q0.30
   localparam int COEF_W     = 30;
   localparam int COEF_SHIFT = 30;

   // Stream beat widths
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 8;

   // 0.5/cos(pi/2^(t+1)) for rounds t = 1..8
   localparam logic [COEF_W-1:0] INNER_COEF [ECC_ROUND_CAP] = '{
      30'd759250125, 30'd581104888, 30'd547388835, 30'd539468601,
      30'd537518376, 30'd537032656, 30'd536911340, 30'd536881019
   };

   // 0.5/cos^2(pi/2^(t+2)) for rounds t = 1..8
   localparam logic [COEF_W-1:0] OUTER_COEF [ECC_ROUND_CAP] = '{
      30'd628983398, 30'd558112816, 30'd542078859, 30'd538166622,
      30'd537194449, 30'd536951772, 30'd536891125, 30'd536875965
   };

   typedef struct packed {
      logic valid;
      logic busy;
      logic hit;
   } ecc_ctl_type;

   // signed width of a fixed-point coordinate or difference
   function automatic int coord_w(input int fb);
      return fb + 16;
   endfunction

   // signed width of a sum of two scaled products
   function automatic int sum_w(input int fb);
      return fb + 32;
   endfunction

endpackage

### design/ecc_quick.sv
module ecc_quick #(
   parameter int FRACTION_BITS = ecc_pkg::ECC_FRACTION_BITS
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            en,
   input  logic                                            in_valid,
   input  logic signed [15:0]                              ellipse_cx,
   input  logic signed [15:0]                              ellipse_cy,
   input  logic        [11:0]                              half_width,
   input  logic        [11:0]                              half_height,
   input  logic signed [15:0]                              circle_cx,
   input  logic signed [15:0]                              circle_cy,
   input  logic        [11:0]                              radius,
   output ecc_pkg::ecc_ctl_type                            ctl_o,
   output logic signed [ecc_pkg::coord_w(FRACTION_BITS)-1:0] px_o,
   output logic signed [ecc_pkg::coord_w(FRACTION_BITS)-1:0] py_o,
   output logic signed [ecc_pkg::coord_w(FRACTION_BITS)-1:0] e0x_o,
   output logic signed [ecc_pkg::coord_w(FRACTION_BITS)-1:0] e0y_o,
   output logic signed [ecc_pkg::coord_w(FRACTION_BITS)-1:0] e2x_o,
   output logic signed [ecc_pkg::coord_w(FRACTION_BITS)-1:0] e2y_o,
   output logic signed [ecc_pkg::sum_w(FRACTION_BITS)-1:0]   rr_o
);
   import ecc_pkg::*;

   localparam int PW = coord_w(FRACTION_BITS);
   localparam int LW = sum_w(FRACTION_BITS);

   // stage 1: fold into the first quadrant
   logic              v1_ff;
   logic signed [16:0] ddx, ddy;
   logic [15:0]        x1_in, y1_in, x1_ff, y1_ff;
   logic [11:0]        w1_ff, h1_ff, r1_ff;

   always_comb begin
      ddx   = 17'(circle_cx) - 17'(ellipse_cx);
      ddy   = 17'(circle_cy) - 17'(ellipse_cy);
      x1_in = ddx[16] ? 16'(-ddx) : 16'(ddx);
      y1_in = ddy[16] ? 16'(-ddy) : 16'(ddy);
   end

   // stage 2: first products
   logic               v2_ff;
   logic signed [16:0] hmy, wmx;
   logic [27:0]        xh2_in, yw2_in, xw2_in, yh2_in, xh2_ff, yw2_ff, xw2_ff, yh2_ff;
   logic [23:0]        wh2_in, ww2_in, hh2_in, r22_in, wh2_ff, ww2_ff, hh2_ff, r22_ff;
   logic [31:0]        xx2_in, yy2_in, hy2_in, wx2_in, xx2_ff, yy2_ff, hy2_ff, wx2_ff;
   logic               box2_in, box2_ff;
   logic [15:0]        x2_ff;
   logic [11:0]        w2_ff, h2_ff;

   always_comb begin
      hmy     = $signed({5'b0, h1_ff}) - $signed({1'b0, y1_ff});
      wmx     = $signed({5'b0, w1_ff}) - $signed({1'b0, x1_ff});
      xh2_in  = 28'(x1_ff) * 28'(h1_ff);
      yw2_in  = 28'(y1_ff) * 28'(w1_ff);
      xw2_in  = 28'(x1_ff) * 28'(w1_ff);
      yh2_in  = 28'(y1_ff) * 28'(h1_ff);
      wh2_in  = 24'(w1_ff) * 24'(h1_ff);
      ww2_in  = 24'(w1_ff) * 24'(w1_ff);
      hh2_in  = 24'(h1_ff) * 24'(h1_ff);
      r22_in  = 24'(r1_ff) * 24'(r1_ff);
      xx2_in  = 32'(x1_ff) * 32'(x1_ff);
      yy2_in  = 32'(y1_ff) * 32'(y1_ff);
      hy2_in  = 32'(hmy * hmy);
      wx2_in  = 32'(wmx * wmx);
      box2_in = (x1_ff <= 16'(w1_ff) && y1_ff <= 16'(13'(h1_ff) + 13'(r1_ff)))
             || (y1_ff <= 16'(h1_ff) && x1_ff <= 16'(13'(w1_ff) + 13'(r1_ff)));
   end

   // stage 3: sums and the exact point tests
   logic               v3_ff;
   logic signed [29:0] s3_in, k3_in, s3_ff;
   logic               near3_in, kin3_in, corner3_in, near3_ff, kin3_ff, corner3_ff, box3_ff;
   logic [24:0]        sum3_in, sum3_ff;
   logic [23:0]        r23_ff;
   logic [15:0]        x3_ff, y3_ff;
   logic [11:0]        w3_ff, h3_ff;
   logic [15:0]        y2_ff;

   always_comb begin
      s3_in      = 30'(xh2_ff) + 30'(yw2_ff) - 30'(wh2_ff);
      k3_in      = 30'(xw2_ff) - 30'(yh2_ff);
      kin3_in    = (k3_in >= -$signed(30'(hh2_ff))) && (k3_in <= $signed(30'(ww2_ff)));
      near3_in   = (33'(xx2_ff) + 33'(hy2_ff) <= 33'(r22_ff))
                || (33'(wx2_ff) + 33'(yy2_ff) <= 33'(r22_ff))
                || (s3_in <= 0);
      corner3_in = (33'(wx2_ff) + 33'(hy2_ff)) <= 33'(r22_ff);
      sum3_in    = 25'(ww2_ff) + 25'(hh2_ff);
   end

   // stage 4: chord distance products
   logic        v4_ff;
   logic [57:0] ss4_in, ss4_ff;
   logic [48:0] rw4_in, rw4_ff;
   logic        near4_ff, kin4_ff, corner4_ff, box4_ff;
   logic [23:0] r24_ff;
   logic [15:0] x4_ff, y4_ff;
   logic [11:0] w4_ff, h4_ff;

   always_comb begin
      // s is only needed when positive, so its low bits are its magnitude
      ss4_in = 58'(s3_ff[28:0]) * 58'(s3_ff[28:0]);
      rw4_in = 49'(r23_ff) * 49'(sum3_ff);
   end

   // stage 5: verdict and launch of the refinement
   ecc_ctl_type ctl5_in;
   logic        hitq;

   always_comb begin
      hitq          = near4_ff || (ss4_ff <= 58'(rw4_ff) && kin4_ff);
      ctl5_in.valid = v4_ff;
      ctl5_in.hit   = hitq;
      ctl5_in.busy  = !hitq && (corner4_ff || box4_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         ctl_o <= '0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         ctl_o <= ctl5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff      <= x1_in;
         y1_ff      <= y1_in;
         w1_ff      <= half_width;
         h1_ff      <= half_height;
         r1_ff      <= radius;
         xh2_ff     <= xh2_in;
         yw2_ff     <= yw2_in;
         xw2_ff     <= xw2_in;
         yh2_ff     <= yh2_in;
         wh2_ff     <= wh2_in;
         ww2_ff     <= ww2_in;
         hh2_ff     <= hh2_in;
         r22_ff     <= r22_in;
         xx2_ff     <= xx2_in;
         yy2_ff     <= yy2_in;
         hy2_ff     <= hy2_in;
         wx2_ff     <= wx2_in;
         box2_ff    <= box2_in;
         x2_ff      <= x1_ff;
         y2_ff      <= y1_ff;
         w2_ff      <= w1_ff;
         h2_ff      <= h1_ff;
         s3_ff      <= s3_in;
         near3_ff   <= near3_in;
         kin3_ff    <= kin3_in;
         corner3_ff <= corner3_in;
         box3_ff    <= box2_ff;
         sum3_ff    <= sum3_in;
         r23_ff     <= r22_ff;
         x3_ff      <= x2_ff;
         y3_ff      <= y2_ff;
         w3_ff      <= w2_ff;
         h3_ff      <= h2_ff;
         ss4_ff     <= ss4_in;
         rw4_ff     <= rw4_in;
         near4_ff   <= near3_ff;
         kin4_ff    <= kin3_ff;
         corner4_ff <= corner3_ff;
         box4_ff    <= box3_ff;
         r24_ff     <= r23_ff;
         x4_ff      <= x3_ff;
         y4_ff      <= y3_ff;
         w4_ff      <= w3_ff;
         h4_ff      <= h3_ff;
         px_o       <= PW'({x4_ff, {FRACTION_BITS{1'b0}}});
         py_o       <= PW'({y4_ff, {FRACTION_BITS{1'b0}}});
         e0x_o      <= PW'({w4_ff, {FRACTION_BITS{1'b0}}});
         e0y_o      <= '0;
         e2x_o      <= '0;
         e2y_o      <= PW'({h4_ff, {FRACTION_BITS{1'b0}}});
         rr_o       <= LW'({r24_ff, {FRACTION_BITS{1'b0}}});
      end
   end

endmodule

### design/ecc_round.sv
module ecc_round #(
   parameter int FRACTION_BITS = ecc_pkg::ECC_FRACTION_BITS,
   parameter int ROUND         = 0
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              en,
   input  ecc_pkg::ecc_ctl_type                              ctl_i,
   input  logic signed [ecc_pkg::coord_w(FRACTION_BITS)-1:0] px_i,
   input  logic signed [ecc_pkg::coord_w(FRACTION_BITS)-1:0] py_i,
   input  logic signed [ecc_pkg::coord_w(FRACTION_BITS)-1:0] e0x_i,
   input  logic signed [ecc_pkg::coord_w(FRACTION_BITS)-1:0] e0y_i,
   input  logic signed [ecc_pkg::coord_w(FRACTION_BITS)-1:0] e2x_i,
   input  logic signed [ecc_pkg::coord_w(FRACTION_BITS)-1:0] e2y_i,
   input  logic signed [ecc_pkg::sum_w(FRACTION_BITS)-1:0]   rr_i,
   output ecc_pkg::ecc_ctl_type                              ctl_o,
   output logic signed [ecc_pkg::coord_w(FRACTION_BITS)-1:0] px_o,
   output logic signed [ecc_pkg::coord_w(FRACTION_BITS)-1:0] py_o,
   output logic signed [ecc_pkg::coord_w(FRACTION_BITS)-1:0] e0x_o,
   output logic signed [ecc_pkg::coord_w(FRACTION_BITS)-1:0] e0y_o,
   output logic signed [ecc_pkg::coord_w(FRACTION_BITS)-1:0] e2x_o,
   output logic signed [ecc_pkg::coord_w(FRACTION_BITS)-1:0] e2y_o,
   output logic signed [ecc_pkg::sum_w(FRACTION_BITS)-1:0]   rr_o
);
   import ecc_pkg::*;

   localparam int PW = coord_w(FRACTION_BITS);
   localparam int LW = sum_w(FRACTION_BITS);
   localparam int HW = (LW + 1) / 2;
   localparam logic [COEF_W-1:0] CI = INNER_COEF[ROUND];
   localparam logic [COEF_W-1:0] CO = OUTER_COEF[ROUND];

   typedef logic signed [PW-1:0] crd_type;
   typedef logic signed [LW-1:0] acc_type;
   typedef logic [2*HW-1:0]      part_type;

   typedef struct packed {
      logic near;
      logic seg2;
      logic seg0;
      logic cr2ok;
      logic cr0ok;
      logic crgok;
      logic q3in;
      logic q4in;
      logic dpos;
      logic dle;
      logic ndle;
      logic x3ok;
      logic x4ok;
   } round_flag_type;

   // (a*b) >> FRACTION_BITS, truncated toward zero
   function automatic acc_type fq(input crd_type a, input crd_type b);
      logic [PW-1:0]   ma, mb;
      logic [2*PW-1:0] prod;
      logic [LW-1:0]   mg;
      ma   = a[PW-1] ? PW'(-a) : PW'(a);
      mb   = b[PW-1] ? PW'(-b) : PW'(b);
      prod = ma * mb;
      mg   = LW'(prod >> FRACTION_BITS);
      fq   = (a[PW-1] ^ b[PW-1]) ? -mg : mg;
   endfunction

   // nonnegative coordinate times a Q0.30 coefficient
   function automatic crd_type fmc(input crd_type a, input logic [COEF_W-1:0] c);
      logic [PW+COEF_W-1:0] prod;
      prod = (PW+COEF_W)'($unsigned(a)) * (PW+COEF_W)'(c);
      fmc  = PW'(prod >> COEF_SHIFT);
   endfunction

   function automatic logic [4*HW-1:0] join_pp(input part_type hh, input part_type hl,
                                               input part_type lh, input part_type ll);
      join_pp = {hh, ll} + ({{(2*HW){1'b0}}, hl} << HW) + ({{(2*HW){1'b0}}, lh} << HW);
   endfunction

   // stage 1: midpoint vertex
   ecc_ctl_type c1_ff;
   crd_type     m1x_in, m1y_in, m1x_ff, m1y_ff, p1x_ff, p1y_ff;
   crd_type     e0x1_ff, e0y1_ff, e2x1_ff, e2y1_ff;
   acc_type     rr1_ff;

   always_comb begin
      m1x_in = fmc(e0x_i + e2x_i, CI);
      m1y_in = fmc(e0y_i + e2y_i, CI);
   end

   // stage 2: outer vertex and edge vectors
   ecc_ctl_type c2_ff;
   crd_type     q3x_in, q3y_in, q3x2_ff, q3y2_ff;
   crd_type     m2x_ff, m2y_ff, p2x_ff, p2y_ff, d2x_ff, d2y_ff;
   crd_type     e0x2_ff, e0y2_ff, e2x2_ff, e2y2_ff;
   crd_type     vx2_ff [2];
   crd_type     vy2_ff [2];
   acc_type     rr2_ff;

   always_comb begin
      q3x_in = fmc(e0x1_ff + m1x_ff, CO);
      q3y_in = fmc(e0y1_ff + m1y_ff, CO);
   end

   // stage 3: scaled products
   ecc_ctl_type c3_ff;
   crd_type     q4x, q4y;
   crd_type     vx3 [3];
   crd_type     vy3 [3];
   acc_type     tdd_in [2];
   acc_type     tdd_ff [2];
   acc_type     tvv_in [3][2];
   acc_type     tvv_ff [3][2];
   acc_type     tdt_in [3][2];
   acc_type     tdt_ff [3][2];
   acc_type     tcr_in [3][2];
   acc_type     tcr_ff [3][2];
   acc_type     tq3_in [2];
   acc_type     tq3_ff [2];
   acc_type     tq4_in [2];
   acc_type     tq4_ff [2];
   acc_type     tx3_in [2];
   acc_type     tx3_ff [2];
   acc_type     tx4_in [2];
   acc_type     tx4_ff [2];
   crd_type     m3x_ff, m3y_ff, p3x_ff, p3y_ff;
   crd_type     e0x3_ff, e0y3_ff, e2x3_ff, e2y3_ff;
   acc_type     rr3_ff;

   always_comb begin
      q4x    = m2x_ff + m2x_ff - q3x2_ff;
      q4y    = m2y_ff + m2y_ff - q3y2_ff;
      vx3[0] = vx2_ff[0];
      vy3[0] = vy2_ff[0];
      vx3[1] = vx2_ff[1];
      vy3[1] = vy2_ff[1];
      vx3[2] = q3x2_ff - m2x_ff;
      vy3[2] = q3y2_ff - m2y_ff;
      tdd_in[0] = fq(d2x_ff, d2x_ff);
      tdd_in[1] = fq(d2y_ff, d2y_ff);
      for (int k = 0; k < 3; k++) begin
         tvv_in[k][0] = fq(vx3[k], vx3[k]);
         tvv_in[k][1] = fq(vy3[k], vy3[k]);
         tdt_in[k][0] = fq(d2x_ff, vx3[k]);
         tdt_in[k][1] = fq(d2y_ff, vy3[k]);
         tcr_in[k][0] = fq(d2y_ff, vx3[k]);
         tcr_in[k][1] = fq(d2x_ff, vy3[k]);
      end
      tq3_in[0] = fq(q3x2_ff - p2x_ff, q3x2_ff - p2x_ff);
      tq3_in[1] = fq(q3y2_ff - p2y_ff, q3y2_ff - p2y_ff);
      tq4_in[0] = fq(q4x - p2x_ff, q4x - p2x_ff);
      tq4_in[1] = fq(q4y - p2y_ff, q4y - p2y_ff);
      tx3_in[0] = fq(p2x_ff - q3x2_ff, e0x2_ff - q3x2_ff);
      tx3_in[1] = fq(p2y_ff - q3y2_ff, e0y2_ff - q3y2_ff);
      tx4_in[0] = fq(p2x_ff - q4x, e2x2_ff - q4x);
      tx4_in[1] = fq(p2y_ff - q4y, e2y2_ff - q4y);
   end

   // stage 4: sums, sign tests and partial products of the exact compares
   ecc_ctl_type    c4_ff;
   round_flag_type f4_in, f4_ff;
   acc_type        dd4, d34, d44, x34, x44;
   acc_type        len4 [3];
   acc_type        dot4 [3];
   acc_type        cr4  [3];
   part_type       ua;
   part_type       ub [3];
   part_type       uc [3];
   part_type       pr_in [3][4];
   part_type       pr_ff [3][4];
   part_type       pc_in [3][4];
   part_type       pc_ff [3][4];
   crd_type        m4x_ff, m4y_ff, p4x_ff, p4y_ff;
   crd_type        e0x4_ff, e0y4_ff, e2x4_ff, e2y4_ff;
   acc_type        rr4_ff;

   always_comb begin
      dd4 = tdd_ff[0] + tdd_ff[1];
      d34 = tq3_ff[0] + tq3_ff[1];
      d44 = tq4_ff[0] + tq4_ff[1];
      x34 = tx3_ff[0] + tx3_ff[1];
      x44 = tx4_ff[0] + tx4_ff[1];
      ua  = (2*HW)'($unsigned(rr3_ff));
      for (int k = 0; k < 3; k++) begin
         len4[k] = tvv_ff[k][0] + tvv_ff[k][1];
         dot4[k] = tdt_ff[k][0] + tdt_ff[k][1];
         cr4[k]  = tcr_ff[k][0] - tcr_ff[k][1];
         ub[k]   = (2*HW)'($unsigned(len4[k]));
         uc[k]   = cr4[k][LW-1] ? (2*HW)'($unsigned(-cr4[k])) : (2*HW)'($unsigned(cr4[k]));
         pr_in[k][0] = ua[2*HW-1:HW] * ub[k][2*HW-1:HW];
         pr_in[k][1] = ua[2*HW-1:HW] * ub[k][HW-1:0];
         pr_in[k][2] = ua[HW-1:0]    * ub[k][2*HW-1:HW];
         pr_in[k][3] = ua[HW-1:0]    * ub[k][HW-1:0];
         pc_in[k][0] = uc[k][2*HW-1:HW] * uc[k][2*HW-1:HW];
         pc_in[k][1] = uc[k][2*HW-1:HW] * uc[k][HW-1:0];
         pc_in[k][2] = uc[k][HW-1:0]    * uc[k][2*HW-1:HW];
         pc_in[k][3] = uc[k][HW-1:0]    * uc[k][HW-1:0];
      end
      f4_in.near  = dd4 <= rr3_ff;
      f4_in.seg2  = dot4[0] >= 0 && dot4[0] <= len4[0];
      f4_in.seg0  = dot4[1] >= 0 && dot4[1] <= len4[1];
      f4_in.cr2ok = cr4[0] >= 0;
      f4_in.cr0ok = cr4[1] <= 0;
      f4_in.crgok = cr4[2] <= 0;
      f4_in.q3in  = d34 < rr3_ff;
      f4_in.q4in  = d44 < rr3_ff;
      f4_in.dpos  = dot4[2] > 0;
      f4_in.dle   = dot4[2] <= len4[2];
      f4_in.ndle  = -dot4[2] <= len4[2];
      f4_in.x3ok  = x34 >= 0;
      f4_in.x4ok  = x44 >= 0;
   end

   // stage 5: exact compares and the vertex update
   ecc_ctl_type       c5_in;
   logic [4*HW-1:0]   bigr [3];
   logic [4*HW-1:0]   bigc [3];
   logic              gpass;
   crd_type           e0x5_in, e0y5_in, e2x5_in, e2y5_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         bigr[k] = join_pp(pr_ff[k][0], pr_ff[k][1], pr_ff[k][2], pr_ff[k][3]);
         bigc[k] = join_pp(pc_ff[k][0], pc_ff[k][1], pc_ff[k][2], pc_ff[k][3]);
      end
      gpass   = f4_ff.crgok || (bigr[2] > bigc[2]);
      c5_in   = c4_ff;
      e0x5_in = e0x4_ff;
      e0y5_in = e0y4_ff;
      e2x5_in = e2x4_ff;
      e2y5_in = e2y4_ff;
      if (c4_ff.busy) begin
         if (f4_ff.near
             || (f4_ff.seg2 && (f4_ff.cr2ok || bigr[0] >= bigc[0]))
             || (f4_ff.seg0 && (f4_ff.cr0ok || bigr[1] >= bigc[1]))) begin
            c5_in.hit  = 1'b1;
            c5_in.busy = 1'b0;
         end else if (f4_ff.q3in
                      || (gpass && f4_ff.dpos && (f4_ff.dle || f4_ff.x3ok))) begin
            if (f4_ff.q3in || !f4_ff.q4in) begin
               e2x5_in = m4x_ff;
               e2y5_in = m4y_ff;
            end else begin
               e0x5_in = m4x_ff;
               e0y5_in = m4y_ff;
            end
         end else if (f4_ff.q4in
                      || (gpass && !f4_ff.dpos && (f4_ff.ndle || f4_ff.x4ok))) begin
            e0x5_in = m4x_ff;
            e0y5_in = m4y_ff;
         end else begin
            c5_in.busy = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
         ctl_o <= '0;
      end else if (en) begin
         c1_ff <= ctl_i;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
         c4_ff <= c3_ff;
         ctl_o <= c5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1x_ff  <= m1x_in;
         m1y_ff  <= m1y_in;
         p1x_ff  <= px_i;
         p1y_ff  <= py_i;
         e0x1_ff <= e0x_i;
         e0y1_ff <= e0y_i;
         e2x1_ff <= e2x_i;
         e2y1_ff <= e2y_i;
         rr1_ff  <= rr_i;

         q3x2_ff   <= q3x_in;
         q3y2_ff   <= q3y_in;
         m2x_ff    <= m1x_ff;
         m2y_ff    <= m1y_ff;
         p2x_ff    <= p1x_ff;
         p2y_ff    <= p1y_ff;
         d2x_ff    <= p1x_ff - m1x_ff;
         d2y_ff    <= p1y_ff - m1y_ff;
         vx2_ff[0] <= e2x1_ff - m1x_ff;
         vy2_ff[0] <= e2y1_ff - m1y_ff;
         vx2_ff[1] <= e0x1_ff - m1x_ff;
         vy2_ff[1] <= e0y1_ff - m1y_ff;
         e0x2_ff   <= e0x1_ff;
         e0y2_ff   <= e0y1_ff;
         e2x2_ff   <= e2x1_ff;
         e2y2_ff   <= e2y1_ff;
         rr2_ff    <= rr1_ff;

         tdd_ff  <= tdd_in;
         tvv_ff  <= tvv_in;
         tdt_ff  <= tdt_in;
         tcr_ff  <= tcr_in;
         tq3_ff  <= tq3_in;
         tq4_ff  <= tq4_in;
         tx3_ff  <= tx3_in;
         tx4_ff  <= tx4_in;
         m3x_ff  <= m2x_ff;
         m3y_ff  <= m2y_ff;
         p3x_ff  <= p2x_ff;
         p3y_ff  <= p2y_ff;
         e0x3_ff <= e0x2_ff;
         e0y3_ff <= e0y2_ff;
         e2x3_ff <= e2x2_ff;
         e2y3_ff <= e2y2_ff;
         rr3_ff  <= rr2_ff;

         f4_ff   <= f4_in;
         pr_ff   <= pr_in;
         pc_ff   <= pc_in;
         m4x_ff  <= m3x_ff;
         m4y_ff  <= m3y_ff;
         p4x_ff  <= p3x_ff;
         p4y_ff  <= p3y_ff;
         e0x4_ff <= e0x3_ff;
         e0y4_ff <= e0y3_ff;
         e2x4_ff <= e2x3_ff;
         e2y4_ff <= e2y3_ff;
         rr4_ff  <= rr3_ff;

         px_o  <= p4x_ff;
         py_o  <= p4y_ff;
         e0x_o <= e0x5_in;
         e0y_o <= e0y5_in;
         e2x_o <= e2x5_in;
         e2y_o <= e2y5_in;
         rr_o  <= rr4_ff;
      end
   end

   // a settled item passes through untouched
   a_settled_pass: assert property (@(posedge clock) disable iff (reset)
      (en && !c4_ff.busy) |=> (ctl_o == $past(c4_ff)))
      else $error("settled item changed in refinement round");

   // an item still refining carries no verdict
   a_busy_no_hit: assert property (@(posedge clock) disable iff (reset)
      ctl_o.busy |-> !ctl_o.hit)
      else $error("refining item carries a hit");

   // a stall freezes the round
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(ctl_o) && $stable(c4_ff))
      else $error("round advanced during a stall");

endmodule

### design/ellipse_circle_collision.sv
// A request beat passes the quick tests and then each refinement round.
// Throughput: one beat per cycle; every stage is a register and the whole pipe stalls
// together when the response beat is not taken.
// Reset: synchronous, active high; clears every stage valid bit, the pipe comes up empty.
// No state survives between items.
module ellipse_circle_collision #(
   parameter int MAX_ITERATIONS = ecc_pkg::ECC_MAX_ITERATIONS,
   parameter int FRACTION_BITS  = ecc_pkg::ECC_FRACTION_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // ellipse_cx[15:0], ellipse_cy[31:16], half_width[43:32], half_height[55:44],
   // circle_cx[71:56], circle_cy[87:72], radius[99:88], zero fill[103:100]
   input  logic [ecc_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // hit[0], zero fill[7:1]
   output logic [ecc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import ecc_pkg::*;

   localparam int PW = coord_w(FRACTION_BITS);
   localparam int LW = sum_w(FRACTION_BITS);

   // advance the whole pipe unless the output register holds an untaken beat
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // chain between the quick tests and the refinement rounds
   ecc_ctl_type          ctl_c [MAX_ITERATIONS+1];
   logic signed [PW-1:0] px_c  [MAX_ITERATIONS+1];
   logic signed [PW-1:0] py_c  [MAX_ITERATIONS+1];
   logic signed [PW-1:0] e0x_c [MAX_ITERATIONS+1];
   logic signed [PW-1:0] e0y_c [MAX_ITERATIONS+1];
   logic signed [PW-1:0] e2x_c [MAX_ITERATIONS+1];
   logic signed [PW-1:0] e2y_c [MAX_ITERATIONS+1];
   logic signed [LW-1:0] rr_c  [MAX_ITERATIONS+1];

   // fold the circle into the first quadrant, run the exact accept and
   // reject tests, and seed the quarter-arc polygon
   ecc_quick #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_quick (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_tvalid),
      .ellipse_cx (req_tdata[15:0]),
      .ellipse_cy (req_tdata[31:16]),
      .half_width (req_tdata[43:32]),
      .half_height(req_tdata[55:44]),
      .circle_cx  (req_tdata[71:56]),
      .circle_cy  (req_tdata[87:72]),
      .radius     (req_tdata[99:88]),
      .ctl_o      (ctl_c[0]),
      .px_o       (px_c[0]),
      .py_o       (py_c[0]),
      .e0x_o      (e0x_c[0]),
      .e0y_o      (e0y_c[0]),
      .e2x_o      (e2x_c[0]),
      .e2y_o      (e2y_c[0]),
      .rr_o       (rr_c[0])
   );

   // one pipelined unit per refinement round; a settled item rides through
   for (genvar i = 0; i < MAX_ITERATIONS; i++) begin : g_round
      ecc_round #(
         .FRACTION_BITS(FRACTION_BITS),
         .ROUND        (i)
      ) u_round (
         .clock(clock),
         .reset(reset),
         .en   (en),
         .ctl_i(ctl_c[i]),
         .px_i (px_c[i]),
         .py_i (py_c[i]),
         .e0x_i(e0x_c[i]),
         .e0y_i(e0y_c[i]),
         .e2x_i(e2x_c[i]),
         .e2y_i(e2y_c[i]),
         .rr_i (rr_c[i]),
         .ctl_o(ctl_c[i+1]),
         .px_o (px_c[i+1]),
         .py_o (py_c[i+1]),
         .e0x_o(e0x_c[i+1]),
         .e0y_o(e0y_c[i+1]),
         .e2x_o(e2x_c[i+1]),
         .e2y_o(e2y_c[i+1]),
         .rr_o (rr_c[i+1])
      );
   end

   // the last round's register is the output register; an item still
   // refining when the rounds run out reports no hit
   assign rsp_tvalid = ctl_c[MAX_ITERATIONS].valid;
   assign rsp_tdata  = {{(RSP_DATA_W-1){1'b0}}, ctl_c[MAX_ITERATIONS].hit};

endmodule

### sim/ellipse_circle_collision_test.sv
`timescale 1ns / 100ps

module ellipse_circle_collision_test;

   import ecc_pkg::*;

   // One ellipse/circle pair, one request beat.
   typedef struct {
      logic signed [15:0] ell_x;
      logic signed [15:0] ell_y;
      logic [11:0]        semi_w;
      logic [11:0]        semi_h;
      logic signed [15:0] circ_x;
      logic signed [15:0] circ_y;
      logic [11:0]        rad;
   } pair_type;

   // Directed row: the pair plus the answer where it is obvious (-1 = use the predictor).
   typedef struct {
      pair_type pair;
      int       answer;
   } pair_row_type;

   localparam int        NUM_RANDOM     = 600;
   localparam int        IDLE_PCT       = 34;
   localparam int        STALL_LIMIT    = 4000;
   localparam int        DRAIN_CYCLES   = 5 + 5 * ECC_MAX_ITERATIONS + 10;
   localparam int        ROUNDS         = (ECC_MAX_ITERATIONS < 8) ? ECC_MAX_ITERATIONS : 8;
   localparam longint    INT64_TOP      = 64'sh7FFF_FFFF_FFFF_FFFF;
   // receiver hold-off and the quiet stretch, in cycles since reset release
   localparam int        HOLD_START     = 400;
   localparam int        HOLD_CYCLES    = 300;
   localparam int        QUIET_START    = 900;
   localparam int        QUIET_CYCLES   = 300;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   logic                   hit_expect_q[$];
   int                     error_count;
   int                     cycle_count;
   int                     idle_run;
   int                     hits_seen;
   int                     misses_seen;
   int                     pairs_sent;
   bit                     stimulus_done;

   ellipse_circle_collision dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Fixed-point predictor of the overlap test
   // ---------------------------------------------------------------------------------

   // (a*b) >> sh, exact product, truncated toward zero, saturated to the int64 top
   function automatic longint scaled_mul(input longint a, input longint b, input int sh);
      bit [63:0]  mag_a;
      bit [63:0]  mag_b;
      bit [127:0] prod;
      longint     m;
      mag_a = (a < 0) ? -a : a;
      mag_b = (b < 0) ? -b : b;
      prod  = {64'd0, mag_a} * {64'd0, mag_b};
      prod  = prod >> sh;
      if (prod > 128'h7FFF_FFFF_FFFF_FFFF) m = INT64_TOP;
      else m = prod[63:0];
      return ((a < 0) != (b < 0)) ? -m : m;
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      return scaled_mul(a, b, ECC_FRACTION_BITS);
   endfunction

   // sign of rr*len - cr*cr, exact
   function automatic int dist_sign(input longint rr, input longint len, input longint cr);
      bit [63:0]  ur;
      bit [63:0]  ul;
      bit [63:0]  uc;
      bit [127:0] lhs;
      bit [127:0] rhs;
      ur  = (rr < 0) ? 64'd0 : rr;
      ul  = (len < 0) ? 64'd0 : len;
      uc  = (cr < 0) ? -cr : cr;
      lhs = {64'd0, ur} * {64'd0, ul};
      rhs = {64'd0, uc} * {64'd0, uc};
      if (lhs == rhs) return 0;
      return (lhs < rhs) ? -1 : 1;
   endfunction

   // Refine the inner and outer polygons of the quarter arc between e0 and e2.
   function automatic bit arc_refine(input longint px, input longint py,
                                     input longint e0x, input longint e0y,
                                     input longint e2x, input longint e2y,
                                     input longint rr);
      longint ci, co, mx, my, dx, dy, ax, ay, len, dot, cr;
      longint q3x, q3y, q4x, q4y, gx, gy;
      for (int t = 0; t < ROUNDS; t++) begin
         ci = INNER_COEF[t];
         co = OUTER_COEF[t];
         mx = scaled_mul(e0x + e2x, ci, COEF_SHIFT);
         my = scaled_mul(e0y + e2y, ci, COEF_SHIFT);
         dx = px - mx;
         dy = py - my;
         if (qmul(dx, dx) + qmul(dy, dy) <= rr) return 1'b1;

         ax  = e2x - mx;
         ay  = e2y - my;
         len = qmul(ax, ax) + qmul(ay, ay);
         dot = qmul(dx, ax) + qmul(dy, ay);
         cr  = qmul(dy, ax) - qmul(dx, ay);
         if (dot >= 0 && dot <= len && (cr >= 0 || dist_sign(rr, len, cr) >= 0)) return 1'b1;

         ax  = e0x - mx;
         ay  = e0y - my;
         len = qmul(ax, ax) + qmul(ay, ay);
         dot = qmul(dx, ax) + qmul(dy, ay);
         cr  = qmul(dy, ax) - qmul(dx, ay);
         if (dot >= 0 && dot <= len && (cr <= 0 || dist_sign(rr, len, cr) >= 0)) return 1'b1;

         q3x = scaled_mul(e0x + mx, co, COEF_SHIFT);
         q3y = scaled_mul(e0y + my, co, COEF_SHIFT);
         if (qmul(q3x - px, q3x - px) + qmul(q3y - py, q3y - py) < rr) begin
            e2x = mx; e2y = my;
            continue;
         end
         q4x = mx - q3x + mx;
         q4y = my - q3y + my;
         if (qmul(q4x - px, q4x - px) + qmul(q4y - py, q4y - py) < rr) begin
            e0x = mx; e0y = my;
            continue;
         end
         gx  = q3x - mx;
         gy  = q3y - my;
         len = qmul(gx, gx) + qmul(gy, gy);
         dot = qmul(dx, gx) + qmul(dy, gy);
         cr  = qmul(dy, gx) - qmul(dx, gy);
         if (cr <= 0 || dist_sign(rr, len, cr) > 0) begin
            if (dot > 0) begin
               if (dot <= len
                   || qmul(px - q3x, e0x - q3x) + qmul(py - q3y, e0y - q3y) >= 0) begin
                  e2x = mx; e2y = my;
                  continue;
               end
            end else if (-dot <= len
                         || qmul(px - q4x, e2x - q4x) + qmul(py - q4y, e2y - q4y) >= 0) begin
               e0x = mx; e0y = my;
               continue;
            end
         end
         return 1'b0;
      end
      // rounds exhausted: no hit
      return 1'b0;
   endfunction

   function automatic bit overlap_predict(input pair_type p);
      longint x, y, w, h, r, r2, s, k, one;
      x   = longint'(p.circ_x) - longint'(p.ell_x);
      y   = longint'(p.circ_y) - longint'(p.ell_y);
      w   = p.semi_w;
      h   = p.semi_h;
      r   = p.rad;
      r2  = r * r;
      one = longint'(1) << ECC_FRACTION_BITS;
      // fold the circle into the first quadrant
      if (x < 0) x = -x;
      if (y < 0) y = -y;
      s = x * h + y * w - w * h;
      k = x * w - y * h;
      if (x * x + (h - y) * (h - y) <= r2 || (w - x) * (w - x) + y * y <= r2 || s <= 0
          || (s * s <= r2 * (w * w + h * h) && k >= -h * h && k <= w * w))
         return 1'b1;
      if ((x - w) * (x - w) + (y - h) * (y - h) <= r2 || (x <= w && y - r <= h)
          || (y <= h && x - r <= w))
         return arc_refine(x * one, y * one, w * one, 0, 0, h * one, r2 * one);
      return 1'b0;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_pair(input pair_type p);
      return {4'd0, p.rad, p.circ_y, p.circ_x, p.semi_h, p.semi_w, p.ell_y, p.ell_x};
   endfunction

   function automatic pair_type make_pair(input int ex, input int ey, input int w,
                                          input int h, input int cx, input int cy,
                                          input int r);
      pair_type p;
      p.ell_x  = ex[15:0];
      p.ell_y  = ey[15:0];
      p.semi_w = w[11:0];
      p.semi_h = h[11:0];
      p.circ_x = cx[15:0];
      p.circ_y = cy[15:0];
      p.rad    = r[11:0];
      return p;
   endfunction

   // Mostly pairs near the arc, where the refinement decides; the rest is raw noise.
   function automatic pair_type random_pair();
      pair_type p;
      int       w, h, r, ex, ey, dx, dy;
      if ($urandom_range(99) < 25) begin
         p.ell_x  = 16'($urandom);
         p.ell_y  = 16'($urandom);
         p.semi_w = 12'($urandom);
         p.semi_h = 12'($urandom);
         p.circ_x = 16'($urandom);
         p.circ_y = 16'($urandom);
         p.rad    = 12'($urandom);
         return p;
      end
      if ($urandom_range(99) < 8) begin
         w = $urandom_range(4095);
         h = $urandom_range(4095);
         r = $urandom_range(4095);
      end else begin
         w = $urandom_range(200);
         h = $urandom_range(200);
         r = $urandom_range(40);
      end
      ex = $urandom_range(65535) - 32768;
      ey = $urandom_range(65535) - 32768;
      dx = $urandom_range(2 * (w + r + 3)) - (w + r + 3);
      dy = $urandom_range(2 * (h + r + 3)) - (h + r + 3);
      return make_pair(ex, ey, w, h, ex + dx, ey + dy, r);
   endfunction

   // Directed pairs: extremes, degenerate ellipses, tangent points.
   pair_row_type directed_rows[] = '{
      '{make_pair(0, 0, 10, 5, 0, 0, 1), 1},                          // concentric
      '{make_pair(100, -100, 0, 0, 3000, 3000, 0), 1},                // both half-axes zero
      '{make_pair(0, 0, 0, 100, 0, 1000, 1), 1},                      // flat, center on line
      '{make_pair(0, 0, 0, 100, 50, 50, 1), 0},                       // flat, off the line
      '{make_pair(-32768, 0, 4095, 4095, 32767, 0, 4095), 0},         // widest spread
      '{make_pair(0, 0, 40, 20, 40, 0, 0), 1},                        // point on x vertex
      '{make_pair(0, 0, 40, 20, 0, -20, 0), 1},                       // point on y vertex
      '{make_pair(32767, 32767, 4095, 4095, 32767, 32767, 4095), -1}, // all maximal
      '{make_pair(-32768, -32768, 0, 4095, -32768, 32767, 0), -1},
      '{make_pair(0, 0, 4095, 1, 3000, 2000, 4095), -1},
      '{make_pair(0, 0, 100, 50, 80, 40, 1), -1},                     // near the arc
      '{make_pair(0, 0, 100, 50, -71, -36, 0), -1},
      '{make_pair(0, 0, 100, 50, 75, 36, 3), -1},
      '{make_pair(10, 10, 3, 200, 14, 150, 1), -1},
      '{make_pair(0, 0, 1, 1, 1, 1, 0), -1},                          // tiny ellipse, corner
      '{make_pair(0, 0, 4095, 4095, 2896, 2896, 1), -1},
      '{make_pair(0, 0, 60, 60, 45, 45, 2), -1},
      '{make_pair(-5, 7, 30, 10, -40, 17, 5), -1}
   };

   // ---------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------

   // Offer one pair and hold it until the beat is taken; idle first at random.
   task automatic offer_pair(input pair_type p, input int answer);
      bit hit_val;
      while (!(cycle_count >= QUIET_START && cycle_count < QUIET_START + QUIET_CYCLES)
             && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= pack_pair(p);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      hit_val = overlap_predict(p);
      if (answer >= 0 && hit_val != answer[0]) begin
         $error("directed pair %0d: predictor says hit=%0b, table says %0d",
                pairs_sent, hit_val, answer);
         error_count++;
      end
      hit_expect_q.push_back((answer >= 0) ? answer[0] : hit_val);
      pairs_sent++;
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      error_count   = 0;
      pairs_sent    = 0;
      stimulus_done = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) offer_pair(directed_rows[i].pair, directed_rows[i].answer);
      repeat (NUM_RANDOM) offer_pair(random_pair(), -1);
      req_tvalid <= 1'b0;
      stimulus_done = 1'b1;

      // drain: wait for every answer, then give the pipe its latency
      wait (hit_expect_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d pairs (%0d directed): %0d hits, %0d misses, with stalls and a",
               pairs_sent, directed_rows.size(), hits_seen, misses_seen);
      $display("long receiver hold-off that backed the pipe up into the request side.");
      if (error_count == 0 && hit_expect_q.size() == 0) begin
         $display("ellipse_circle_collision_test: PASS");
      end else begin
         $display("ellipse_circle_collision_test: FAIL");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Response side, checker and watchdog
   // ---------------------------------------------------------------------------------
   initial begin
      rsp_tready  = 1'b0;
      cycle_count = 0;
      idle_run    = 0;
      hits_seen   = 0;
      misses_seen = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         cycle_count <= cycle_count + 1;

         // check the beat taken at this edge against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (hit_expect_q.size() == 0) begin
               $error("response beat with no pair outstanding: hit=%0b", rsp_tdata[0]);
               error_count++;
            end else begin
               if (rsp_tdata[0] !== hit_expect_q[0]) begin
                  $error("hit mismatch: expected %0b, actual %0b", hit_expect_q[0],
                         rsp_tdata[0]);
                  error_count++;
               end
               if (rsp_tdata[0]) hits_seen++;
               else misses_seen++;
               void'(hit_expect_q.pop_front());
            end
         end

         // count cycles with no beat on either side
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)
             || (stimulus_done && hit_expect_q.size() == 0)) begin
            idle_run <= 0;
         end else if (idle_run >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("ellipse_circle_collision_test: FAIL");
            $finish;
         end else begin
            idle_run <= idle_run + 1;
         end

         // hold off for a long stretch once, never stall in the quiet stretch
         if (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_CYCLES)
            rsp_tready <= 1'b0;
         else if (cycle_count >= QUIET_START && cycle_count < QUIET_START + QUIET_CYCLES)
            rsp_tready <= 1'b1;
         else
            rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

endmodule
